### rtl/lkvc_pkg.sv
// ----------------------------------------------------------------------------
// lkvc_pkg: shared types and constants for the LRU key-value cache
// Sizes, operation codes, register map and controller/datapath structs.
// ----------------------------------------------------------------------------
`default_nettype none

package lkvc_pkg;

  // Number of cache slots
  localparam int ENTRIES = 16;

  // Slot index, rank and occupancy widths follow from the slot count
  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W = $clog2(ENTRIES + 1);

  // Request and response field widths
  localparam int KEY_W = 32;
  localparam int VAL_W = 32;

  // Capacity register
  localparam int          CAP_W     = 5;
  localparam int          CMP_W     = (CNT_W > CAP_W) ? CNT_W : CAP_W;
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  // Configuration port
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic REG_CAPACITY = 1'b0;  // word index of the capacity register

  // Operation codes
  localparam logic KIND_GET = 1'b0;
  localparam logic KIND_PUT = 1'b1;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;   // latch the accepted request
    logic lookup;    // register compare, free slot and victim search
    logic update;    // apply ranks, keys, valid bits and value RAM access
    logic load_rsp;  // move the result into the response register
  } lkvc_cmd_t;

  // Datapath status
  typedef struct packed {
    logic empty;     // no slot occupied
  } lkvc_sts_t;

endpackage

`default_nettype wire

### rtl/lkvc_req_if.sv
// ----------------------------------------------------------------------------
// lkvc_req_if: request channel
// Valid/ready channel carrying one get or put request.
// ----------------------------------------------------------------------------
`default_nettype none

interface lkvc_req_if import lkvc_pkg::*; ();

  logic                    valid;
  logic                    ready;
  logic                    kind;
  logic signed [KEY_W-1:0] key;
  logic signed [VAL_W-1:0] value;

  modport source (output valid, output kind, output key, output value, input ready);
  modport sink   (input valid, input kind, input key, input value, output ready);

endinterface

`default_nettype wire

### rtl/lkvc_rsp_if.sv
// ----------------------------------------------------------------------------
// lkvc_rsp_if: response channel
// Valid/ready channel carrying one result per request.
// ----------------------------------------------------------------------------
`default_nettype none

interface lkvc_rsp_if import lkvc_pkg::*; ();

  logic                    valid;
  logic                    ready;
  logic                    found;
  logic signed [VAL_W-1:0] read_value;
  logic                    evicted;

  modport source (output valid, output found, output read_value, output evicted,
                  input ready);
  modport sink   (input valid, input found, input read_value, input evicted,
                  output ready);

endinterface

`default_nettype wire

### rtl/lkvc_ram.sv
// ----------------------------------------------------------------------------
// lkvc_ram: generic single-port RAM
// One access per cycle, write or read, with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module lkvc_ram #(
  parameter  int WIDTH = 32,
  parameter  int DEPTH = 16,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic             re,
  input  wire logic [AW-1:0]    addr,
  input  wire logic [WIDTH-1:0] wdata,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

`default_nettype wire

### rtl/lkvc_ctrl.sv
// ----------------------------------------------------------------------------
// lkvc_ctrl: request sequencer
// Steps each request through capture, lookup, update and response load.
// ----------------------------------------------------------------------------
`default_nettype none

module lkvc_ctrl import lkvc_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic req_valid,
  output logic      req_ready,
  output logic      rsp_valid,
  input  wire logic rsp_ready,
  output lkvc_cmd_t cmd
);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_LOOKUP = 4'b0010,
    ST_UPDATE = 4'b0100,
    ST_FINISH = 4'b1000
  } lkvc_state_t;

  lkvc_state_t state, state_next;
  logic        rsp_valid_next;
  logic        rsp_free;

  assign req_ready = (state == ST_IDLE);
  assign rsp_free  = !rsp_valid || rsp_ready;

  always_comb begin
    state_next   = state;
    cmd          = '0;
    case (state)
      ST_IDLE: begin
        if (req_valid) begin
          cmd.capture = 1'b1;
          state_next  = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        cmd.lookup = 1'b1;
        state_next = ST_UPDATE;
      end
      ST_UPDATE: begin
        cmd.update = 1'b1;
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        // hold until the response register can take the result
        if (rsp_free) begin
          cmd.load_rsp = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    rsp_valid_next = rsp_valid;
    if (cmd.load_rsp) begin
      rsp_valid_next = 1'b1;
    end else if (rsp_ready) begin
      rsp_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      rsp_valid <= rsp_valid_next;
    end
  end

endmodule

`default_nettype wire

### rtl/lkvc_dpath.sv
// ----------------------------------------------------------------------------
// lkvc_dpath: cache datapath
// Key compare array, recency ranks, valid bits, occupancy and value RAM.
// ----------------------------------------------------------------------------
`default_nettype none

module lkvc_dpath import lkvc_pkg::*; (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire lkvc_cmd_t               cmd,
  output lkvc_sts_t                    sts,
  input  wire logic [CAP_W-1:0]        capacity,
  input  wire logic                    req_kind,
  input  wire logic signed [KEY_W-1:0] req_key,
  input  wire logic signed [VAL_W-1:0] req_value,
  output logic                         rsp_found,
  output logic signed [VAL_W-1:0]      rsp_read_value,
  output logic                         rsp_evicted
);

  // captured request
  logic             op_kind;
  logic [KEY_W-1:0] op_key;
  logic [VAL_W-1:0] op_value;

  // slot state
  logic [ENTRIES-1:0] entry_valid;
  logic [KEY_W-1:0]   entry_key [ENTRIES];
  logic [IDX_W-1:0]   rank      [ENTRIES];
  logic [CNT_W-1:0]   occupied;

  // lookup results
  logic [IDX_W-1:0] hit_idx_c, free_idx_c, lru_idx_c;
  logic             hit_c, full_c;
  logic [CMP_W-1:0] cap_eff;
  logic [IDX_W-1:0] hit_idx, free_idx, lru_idx;
  logic             hit, full;

  // update controls
  logic             is_put;
  logic             promote, key_we, insert, evict, ram_we, ram_re;
  logic [IDX_W-1:0] slot;
  logic [CNT_W-1:0] thr;

  // per-request result flags
  logic             res_found, res_evicted, res_get_hit;
  logic [VAL_W-1:0] ram_rdata;

  assign sts.empty = (occupied == '0);
  assign is_put    = (op_kind == KIND_PUT);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_kind  <= req_kind;
      op_key   <= req_key;
      op_value <= req_value;
    end
  end

  // Parallel compare, lowest free slot and the slot holding the oldest rank
  always_comb begin
    hit_c      = 1'b0;
    hit_idx_c  = '0;
    free_idx_c = '0;
    lru_idx_c  = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (entry_valid[i] && (entry_key[i] == op_key)) begin
        hit_c     = 1'b1;
        hit_idx_c = IDX_W'(i);
      end
      if (!entry_valid[i]) begin
        free_idx_c = IDX_W'(i);
      end
      if (entry_valid[i] && (CNT_W'(rank[i]) == occupied - CNT_W'(1))) begin
        lru_idx_c = IDX_W'(i);
      end
    end
  end

  // Clamp capacity into 1 .. ENTRIES
  always_comb begin
    cap_eff = CMP_W'(capacity);
    if (cap_eff == '0) begin
      cap_eff = CMP_W'(1);
    end else if (cap_eff > CMP_W'(ENTRIES)) begin
      cap_eff = CMP_W'(ENTRIES);
    end
    full_c = (CMP_W'(occupied) >= cap_eff);
  end

  always_ff @(posedge clk) begin
    if (cmd.lookup) begin
      hit      <= hit_c;
      hit_idx  <= hit_idx_c;
      free_idx <= free_idx_c;
      lru_idx  <= lru_idx_c;
      full     <= full_c;
    end
  end

  // Pick the slot to touch and the rank threshold below which others age
  always_comb begin
    promote = 1'b0;
    key_we  = 1'b0;
    insert  = 1'b0;
    evict   = 1'b0;
    ram_we  = 1'b0;
    ram_re  = 1'b0;
    slot    = hit_idx;
    thr     = CNT_W'(rank[hit_idx]);
    if (hit) begin
      promote = 1'b1;
      ram_we  = is_put;
      ram_re  = !is_put;
    end else if (is_put) begin
      promote = 1'b1;
      key_we  = 1'b1;
      ram_we  = 1'b1;
      if (full) begin
        evict = 1'b1;
        slot  = lru_idx;
        thr   = occupied - CNT_W'(1);
      end else begin
        insert = 1'b1;
        slot   = free_idx;
        thr    = occupied + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update && promote) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (IDX_W'(i) == slot) begin
          rank[i] <= '0;
        end else if (entry_valid[i] && (CNT_W'(rank[i]) < thr)) begin
          rank[i] <= rank[i] + IDX_W'(1);
        end
      end
    end
    if (cmd.update && key_we) begin
      entry_key[slot] <= op_key;
    end
    if (cmd.update) begin
      res_found   <= hit;
      res_evicted <= evict;
      res_get_hit <= hit && !is_put;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
      occupied    <= '0;
    end else if (cmd.update && insert) begin
      entry_valid[slot] <= 1'b1;
      occupied          <= occupied + CNT_W'(1);
    end
  end

  lkvc_ram #(
    .WIDTH (VAL_W),
    .DEPTH (ENTRIES)
  ) u_value_ram (
    .clk   (clk),
    .we    (cmd.update && ram_we),
    .re    (cmd.update && ram_re),
    .addr  (slot),
    .wdata (op_value),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.load_rsp) begin
      rsp_found      <= res_found;
      rsp_evicted    <= res_evicted;
      rsp_read_value <= res_get_hit ? ram_rdata : '0;
    end
  end

endmodule

`default_nettype wire

### rtl/lru_key_value_cache_core.sv
// ----------------------------------------------------------------------------
// lru_key_value_cache_core: fully associative key-value cache, LRU replacement
// Get/put requests in, one response per request out, APB capacity register.
// ----------------------------------------------------------------------------
// Flow: one request in flight; the controller steps it through capture,
//   parallel key compare, rank/key/value-RAM update and the registered
//   value RAM read, then loads the response register once that register
//   is free, and only then takes the next request.
// Reset: clears the valid bits, the occupancy count and the controller, and
//   sets capacity to 16; keys, ranks and values stay undefined until written.
// ----------------------------------------------------------------------------
`default_nettype none

module lru_key_value_cache_core import lkvc_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  lkvc_req_if.sink                req,
  lkvc_rsp_if.source              rsp,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output logic      [PDATA_W-1:0] prdata,
  output logic                    pready
);

  lkvc_cmd_t        cmd;
  lkvc_sts_t        sts;
  logic [CAP_W-1:0] capacity;
  logic             cap_sel;
  logic             cap_write;

  // Capacity register: one word, no wait states. Drop writes while any slot
  // is occupied so the clamp never sees a capacity below the occupancy.
  assign pready    = 1'b1;
  assign cap_sel   = (paddr[2] == REG_CAPACITY);
  assign cap_write = psel && penable && pwrite && cap_sel && sts.empty;
  assign prdata    = cap_sel ? PDATA_W'(capacity) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (cap_write) begin
      capacity <= pwdata[CAP_W-1:0];
    end
  end

  // Sequencer: one request in flight; the response register frees the input
  // side so the next request may be taken while a response waits.
  lkvc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .cmd       (cmd)
  );

  // Datapath: slot array, recency ranks and the value RAM
  lkvc_dpath u_dpath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .sts            (sts),
    .capacity       (capacity),
    .req_kind       (req.kind),
    .req_key        (req.key),
    .req_value      (req.value),
    .rsp_found      (rsp.found),
    .rsp_read_value (rsp.read_value),
    .rsp_evicted    (rsp.evicted)
  );

endmodule

`default_nettype wire

### rtl/lkvc_checker.sv
// ----------------------------------------------------------------------------
// lkvc_checker: port-level checks for the LRU key-value cache
// Watches the request and response channels of the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module lkvc_checker import lkvc_pkg::*; (
  input wire logic                    clk,
  input wire logic                    rst,
  input wire logic                    req_valid,
  input wire logic                    req_ready,
  input wire logic                    rsp_valid,
  input wire logic                    rsp_ready,
  input wire logic                    rsp_found,
  input wire logic signed [VAL_W-1:0] rsp_read_value,
  input wire logic                    rsp_evicted
);

  // A stalled response stays offered
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("response dropped while stalled");

  // Only one request in flight
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken while another is in flight");

  // A present key never causes an eviction
  a_found_no_evict: assert property (@(posedge clk)
    rsp_valid |-> !(rsp_found && rsp_evicted))
    else $error("eviction reported on a hit");

  // A miss returns zero data
  a_miss_zero: assert property (@(posedge clk)
    rsp_valid && !rsp_found |-> rsp_read_value == '0)
    else $error("nonzero read value on a miss");

  // Reset empties the response register
  a_reset_clear: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("response valid after reset");

endmodule

bind lru_key_value_cache_core lkvc_checker u_lkvc_checker (
  .clk            (clk),
  .rst            (rst),
  .req_valid      (req.valid),
  .req_ready      (req.ready),
  .rsp_valid      (rsp.valid),
  .rsp_ready      (rsp.ready),
  .rsp_found      (rsp.found),
  .rsp_read_value (rsp.read_value),
  .rsp_evicted    (rsp.evicted)
);

`default_nettype wire

### tb/lkvc_checker.sv
// ----------------------------------------------------------------------------
// lkvc_scoreboard: response scoreboard for the LRU key-value cache
// Watches the request, response and register channels. Keeps its own copy
// of the slots and their recency order, predicts each response and compares.
// ----------------------------------------------------------------------------
`default_nettype none

module lkvc_scoreboard import lkvc_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  lkvc_req_if                     req,
  lkvc_rsp_if                     rsp,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic               pready,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output int                      mismatch_count,
  output int                      pending_results
);

  timeunit 1ns;
  timeprecision 1ps;

  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic                    found;
    logic signed [VAL_W-1:0] read_value;
    logic                    evicted;
  } cache_result_t;

  // Shadow copy of the cache
  logic                    slot_valid [ENTRIES];
  logic signed [KEY_W-1:0] slot_key   [ENTRIES];
  logic signed [VAL_W-1:0] slot_value [ENTRIES];
  logic [IDX_W-1:0]        slot_rank  [ENTRIES];
  logic [CNT_W-1:0]        fill_count;
  logic [CAP_W-1:0]        capacity_reg;

  cache_result_t expected_results [$];
  int            errors;

  initial begin
    mismatch_count  = 0;
    pending_results = 0;
    errors          = 0;
  end

  // Make slot s most recent; valid slots ahead of it move back one rank.
  function automatic void promote(int s, int old_rank);
    for (int i = 0; i < ENTRIES; i++) begin
      if (slot_valid[i] && i != s && int'(slot_rank[i]) < old_rank) begin
        slot_rank[i]++;
      end
    end
    slot_rank[s] = '0;
  endfunction

  function automatic cache_result_t lru_access(logic                    kind,
                                               logic signed [KEY_W-1:0] key,
                                               logic signed [VAL_W-1:0] value);
    cache_result_t res;
    int            hit;
    int            slot;
    int            cap_eff;
    res  = '0;
    hit  = -1;
    slot = -1;
    for (int i = 0; i < ENTRIES; i++) begin
      if (hit < 0 && slot_valid[i] && slot_key[i] == key) begin
        hit = i;
      end
    end
    if (hit >= 0) begin
      res.found = 1'b1;
      if (kind == KIND_GET) begin
        res.read_value = slot_value[hit];
      end else begin
        slot_value[hit] = value;
      end
      promote(hit, int'(slot_rank[hit]));
    end else if (kind == KIND_PUT) begin
      // zero acts as one, anything past the slot count saturates
      cap_eff = int'(capacity_reg);
      if (cap_eff == 0) begin
        cap_eff = 1;
      end
      if (cap_eff > ENTRIES) begin
        cap_eff = ENTRIES;
      end
      if (int'(fill_count) >= cap_eff) begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (slot_valid[i]) begin
            if (slot < 0) begin
              slot = i;
            end else if (slot_rank[i] > slot_rank[slot]) begin
              slot = i;
            end
          end
        end
        res.evicted = 1'b1;
        promote(slot, int'(slot_rank[slot]));
      end else begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (slot < 0 && !slot_valid[i]) begin
            slot = i;
          end
        end
        slot_valid[slot] = 1'b1;
        fill_count++;
        promote(slot, int'(fill_count));
      end
      slot_key[slot]   = key;
      slot_value[slot] = value;
    end
    return res;
  endfunction

  always @(posedge clk) begin
    cache_result_t got;
    cache_result_t want;
    if (rst) begin
      for (int i = 0; i < ENTRIES; i++) begin
        slot_valid[i] = 1'b0;
      end
      fill_count   = '0;
      capacity_reg = CAP_RESET;
      expected_results.delete();
    end else begin
      // capacity only takes a write while the cache is empty
      if (psel && penable && pwrite && pready &&
          paddr[PADDR_W-1:2] == REG_CAPACITY && fill_count == 0) begin
        capacity_reg = pwdata[CAP_W-1:0];
      end
      if (req.valid && req.ready) begin
        expected_results.push_back(lru_access(req.kind, req.key, req.value));
      end
      if (rsp.valid && rsp.ready) begin
        got.found      = rsp.found;
        got.read_value = rsp.read_value;
        got.evicted    = rsp.evicted;
        if (expected_results.size() == 0) begin
          errors++;
          if (errors <= REPORT_LIMIT) begin
            $display("%0t: response with none pending: found=%0b read_value=%0d evicted=%0b",
                     $realtime, got.found, got.read_value, got.evicted);
          end
        end else begin
          want = expected_results.pop_front();
          if (got.found !== want.found || got.read_value !== want.read_value ||
              got.evicted !== want.evicted) begin
            errors++;
            if (errors <= REPORT_LIMIT) begin
              $display("%0t: mismatch: expected found=%0b read_value=%0d evicted=%0b",
                       $realtime, want.found, want.read_value, want.evicted);
              $display("%0t:           actual   found=%0b read_value=%0d evicted=%0b",
                       $realtime, got.found, got.read_value, got.evicted);
            end
          end
        end
      end
    end
    mismatch_count  <= errors;
    pending_results <= expected_results.size();
  end

endmodule

`default_nettype wire

### tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench: top level for the LRU key-value cache
// Drives get/put requests and the capacity register, throttles the response
// side, and leaves prediction and comparison to the checker beside the core.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench import lkvc_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int HOLD_CYCLES    = 300;   // long response hold-off
  localparam int WATCHDOG_LIMIT = 4000;  // cycles without any handshake
  localparam int SETTLE_CYCLES  = 8;     // margin after the last response
  localparam int KEY_POOL       = 20;

  // Second word of the register map; no register lives there
  localparam logic REG_SPARE = 1'b1;

  localparam logic signed [KEY_W-1:0] KEY_MIN = {1'b1, {(KEY_W-1){1'b0}}};
  localparam logic signed [KEY_W-1:0] KEY_MAX = {1'b0, {(KEY_W-1){1'b1}}};
  localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};
  localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};

  logic               clk = 1'b0;
  logic               rst;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  int mismatch_count;
  int pending_results;
  int idle_cycles = 0;

  // Flow control between the request process and the response throttle
  bit rsp_hold = 1'b0;
  bit no_idle  = 1'b0;

  logic signed [KEY_W-1:0] key_pool [KEY_POOL];
  int                      pool_span;

  lkvc_req_if req_ch ();
  lkvc_rsp_if rsp_ch ();

  lru_key_value_cache_core i_dut (
    .clk     (clk),
    .rst     (rst),
    .req     (req_ch),
    .rsp     (rsp_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  lkvc_scoreboard i_checker (
    .clk             (clk),
    .rst             (rst),
    .req             (req_ch),
    .rsp             (rsp_ch),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .pready          (pready),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .mismatch_count  (mismatch_count),
    .pending_results (pending_results)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Idle length: mostly none or a few cycles, now and then a long one.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle) begin
      return 0;
    end
    if (r < 50) begin
      return 0;
    end
    if (r < 88) begin
      return $urandom_range(1, 3);
    end
    if (r < 97) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(20, 60);
  endfunction

  // Register write: setup cycle, access cycle, then one cycle with psel low
  // so back-to-back writes never touch psel twice in one step.
  task automatic apb_write(input logic idx, input logic [PDATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // Offer one request, hold it until taken, then idle for a random gap.
  // With a zero gap valid stays high and only the payload advances.
  task automatic issue_request(input logic                    k,
                               input logic signed [KEY_W-1:0] ky,
                               input logic signed [VAL_W-1:0] vl);
    int n;
    req_ch.valid <= 1'b1;
    req_ch.kind  <= k;
    req_ch.key   <= ky;
    req_ch.value <= vl;
    do @(posedge clk); while (!req_ch.ready);
    n = gap_len();
    if (n > 0) begin
      req_ch.valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Drop valid and wait for every outstanding response, then let the
  // pipeline settle before anything touches the register port.
  task automatic drain_responses();
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_results != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Random traffic: keys mostly from a small pool so gets hit and puts
  // update, some fresh keys to miss and evict, a few extreme values.
  task automatic random_phase(input int count);
    logic                    k;
    logic signed [KEY_W-1:0] ky;
    logic signed [VAL_W-1:0] vl;
    int                      r;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 49) == 0) begin
        key_pool[$urandom_range(0, pool_span - 1)] = $urandom;
      end
      r = $urandom_range(0, 99);
      if (r < 85) begin
        ky = key_pool[$urandom_range(0, pool_span - 1)];
      end else if (r < 95) begin
        ky = $urandom;
      end else begin
        case ($urandom_range(0, 3))
          0: ky = KEY_MIN;
          1: ky = KEY_MAX;
          2: ky = '0;
          default: ky = '1;
        endcase
      end
      k = ($urandom_range(0, 99) < 45) ? KIND_PUT : KIND_GET;
      case ($urandom_range(0, 39))
        0: vl = VAL_MIN;
        1: vl = VAL_MAX;
        2: vl = '0;
        default: vl = $urandom;
      endcase
      issue_request(k, ky, vl);
    end
  endtask

  // Response throttle: random on/off stretches, always ready while no_idle
  // is set, and one long hold-off on request, counted here.
  initial begin
    int on_len;
    int off_len;
    rsp_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (rsp_hold) begin
        rsp_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        rsp_hold = 1'b0;
      end else if (no_idle) begin
        rsp_ch.ready <= 1'b1;
        @(posedge clk);
      end else begin
        on_len  = $urandom_range(1, 12);
        off_len = gap_len();
        rsp_ch.ready <= 1'b1;
        repeat (on_len) @(posedge clk);
        if (off_len > 0) begin
          rsp_ch.ready <= 1'b0;
          repeat (off_len) @(posedge clk);
        end
      end
    end
  end

  // Watchdog: any request, response or register access counts as progress.
  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
        (psel && penable)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog expired with %0d responses outstanding",
               $realtime, pending_results);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Main sequence
  initial begin
    logic [CAP_W-1:0] cap_sel;
    int               cap_eff;

    rst          <= 1'b1;
    psel         <= 1'b0;
    penable      <= 1'b0;
    pwrite       <= 1'b0;
    paddr        <= '0;
    pwdata       <= '0;
    req_ch.valid <= 1'b0;
    req_ch.kind  <= KIND_GET;
    req_ch.key   <= '0;
    req_ch.value <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Capacity sticks only while the cache is empty, so the last write here
    // decides the whole run. Pass through the saturating and zero values
    // first, and poke the unmapped word.
    case ($urandom_range(0, 7))
      0: cap_sel = 5'd0;
      1: cap_sel = 5'd1;
      2: cap_sel = 5'd2;
      3: cap_sel = 5'd5;
      4: cap_sel = 5'd15;
      5: cap_sel = 5'd16;
      6: cap_sel = 5'd17;
      default: cap_sel = 5'd31;
    endcase
    apb_write(REG_SPARE, $urandom);
    apb_write(REG_CAPACITY, 32'd31);
    apb_write(REG_CAPACITY, 32'd0);
    apb_write(REG_CAPACITY, PDATA_W'(cap_sel));

    cap_eff = (cap_sel == 0) ? 1 : ((int'(cap_sel) > ENTRIES) ? ENTRIES : int'(cap_sel));
    // Pool a little larger than the capacity: hits and evictions both common
    pool_span = (cap_eff + 4 > KEY_POOL) ? KEY_POOL : cap_eff + 4;
    for (int i = 0; i < KEY_POOL; i++) begin
      key_pool[i] = $urandom;
    end

    // Directed: miss on empty, extreme keys and values, hit after put,
    // update in place, then fill past any capacity so the least recent
    // entries go, a put to a present key while full, and a last get of KEY_MIN.
    issue_request(KIND_GET, '0, VAL_MAX);
    issue_request(KIND_PUT, KEY_MIN, VAL_MAX);
    issue_request(KIND_GET, KEY_MIN, '0);
    issue_request(KIND_PUT, KEY_MAX, VAL_MIN);
    issue_request(KIND_PUT, '0, '1);
    issue_request(KIND_PUT, '1, '0);
    issue_request(KIND_GET, KEY_MAX, '1);
    issue_request(KIND_PUT, KEY_MIN, 32'h5A5A5A5A);
    issue_request(KIND_GET, KEY_MIN, '0);
    for (int i = 0; i < 14; i++) begin
      issue_request(KIND_PUT, KEY_W'(100 + i), $urandom);
    end
    issue_request(KIND_PUT, KEY_W'(113), VAL_MIN);
    issue_request(KIND_GET, KEY_MIN, '0);

    random_phase(500);
    drain_responses();
    // Not empty any more: these capacity writes must be ignored
    apb_write(REG_CAPACITY, 32'd1);
    apb_write(REG_CAPACITY, 32'd16);

    // Hold the response side off for a long stretch while requests keep
    // coming, so the core backs up and stalls its input.
    rsp_hold = 1'b1;
    random_phase(60);
    drain_responses();
    apb_write(REG_SPARE, $urandom);

    // Back-to-back stretch with no idling on either side
    no_idle = 1'b1;
    random_phase(300);
    no_idle = 1'b0;
    drain_responses();
    apb_write(REG_CAPACITY, 32'd31);
    apb_write(REG_CAPACITY, 32'd0);

    random_phase(865);
    drain_responses();

    // Let the last checker update land before reading its counts
    @(negedge clk);
    if (mismatch_count == 0 && pending_results == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

`default_nettype wire

### filelist.f
rtl/lkvc_pkg.sv
rtl/lkvc_req_if.sv
rtl/lkvc_rsp_if.sv
rtl/lkvc_ram.sv
rtl/lkvc_ctrl.sv
rtl/lkvc_dpath.sv
rtl/lru_key_value_cache_core.sv
rtl/lkvc_checker.sv
tb/lkvc_checker.sv
tb/testbench.sv
